[hdl/ttag_pkg.sv]
// ttag_pkg: shared constants, payload and control types, and axis helpers
// for the tensor transpose address generator; no dependencies
package ttag_pkg;

	localparam int MAX_RANK      = 4;
	localparam int DIM_BITS      = 12;
	localparam int AXIS_BITS     = $clog2(MAX_RANK);
	localparam int RANK_BITS     = 3;
	localparam int DIMS_BITS     = 48;
	localparam int PERM_BITS     = 8;
	localparam int PERM_ENT_BITS = 2;
	localparam int EB_BITS       = 4;
	localparam int OFF_BITS      = 51;
	localparam int STRIDE_BITS   = 48;
	localparam int CNT_BITS      = 48;
	localparam int CFG_IDX_BITS  = 8;
	localparam int CFG_DATA_BITS = 48;

	typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_RANK = cfg_idx_t'(0);
	localparam cfg_idx_t REG_DIMS = cfg_idx_t'(1);
	localparam cfg_idx_t REG_PERM = cfg_idx_t'(2);
	localparam cfg_idx_t REG_EB   = cfg_idx_t'(3);

	localparam logic [RANK_BITS-1:0] RANK_RESET = RANK_BITS'(4);
	localparam logic [DIMS_BITS-1:0] DIMS_RESET = 48'd68736258049;
	localparam logic [PERM_BITS-1:0] PERM_RESET = PERM_BITS'(27);
	localparam logic [EB_BITS-1:0]   EB_RESET   = EB_BITS'(1);

	typedef struct packed {
		logic restart;
	} tick_t;

	typedef struct packed {
		logic [OFF_BITS-1:0] src_byte_offset;
		logic [OFF_BITS-1:0] dst_byte_offset;
		logic                last;
		logic                error;
	} addr_t;

	typedef struct packed {
		cfg_idx_t                 index;
		logic [CFG_DATA_BITS-1:0] data;
	} cfg_wr_t;

	typedef struct packed {
		logic [RANK_BITS-1:0] rank;
		logic [DIMS_BITS-1:0] input_dims_packed;
		logic [PERM_BITS-1:0] perm_packed;
		logic [EB_BITS-1:0]   element_bytes;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_STRIDE,
		ST_MAC,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic clear;
		logic stride_step;
		logic mac;
		logic emit;
		logic err;
	} cmd_t;

	typedef struct packed {
		logic stride_last;
		logic mac_last;
		logic out_free;
	} status_t;

	function automatic logic [DIM_BITS-1:0] dim_of(input cfg_t c,
			input logic [AXIS_BITS-1:0] axis);
		return c.input_dims_packed[axis*DIM_BITS +: DIM_BITS];
	endfunction

	function automatic logic [AXIS_BITS-1:0] perm_of(input cfg_t c,
			input logic [AXIS_BITS-1:0] axis);
		return AXIS_BITS'(c.perm_packed[axis*PERM_ENT_BITS +: PERM_ENT_BITS]);
	endfunction

endpackage

[hdl/ttag_tick_if.sv]
// ttag_tick_if: tick channel (valid, ready, restart payload)
// depends on ttag_pkg
interface ttag_tick_if import ttag_pkg::*; ;
	logic  valid;
	logic  ready;
	tick_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

[hdl/ttag_addr_if.sv]
// ttag_addr_if: address result channel (valid, ready, offsets and flags)
// depends on ttag_pkg
interface ttag_addr_if import ttag_pkg::*; ;
	logic  valid;
	logic  ready;
	addr_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

[hdl/ttag_cfg_if.sv]
// ttag_cfg_if: configuration write channel (valid, ready, index and data)
// depends on ttag_pkg
interface ttag_cfg_if import ttag_pkg::*; ;
	logic    valid;
	logic    ready;
	cfg_wr_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

[hdl/ttag_cfg_regs.sv]
// ttag_cfg_regs: configuration register file and configuration check
// depends on ttag_pkg and ttag_cfg_if
module ttag_cfg_regs import ttag_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	ttag_cfg_if.sink   cfg,
	output cfg_t       regs,
	output logic       cfg_ok
);

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.rank              <= RANK_RESET;
			regs_q.input_dims_packed <= DIMS_RESET;
			regs_q.perm_packed       <= PERM_RESET;
			regs_q.element_bytes     <= EB_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.payload.index)
				REG_RANK: regs_q.rank              <= cfg.payload.data[RANK_BITS-1:0];
				REG_DIMS: regs_q.input_dims_packed <= cfg.payload.data[DIMS_BITS-1:0];
				REG_PERM: regs_q.perm_packed       <= cfg.payload.data[PERM_BITS-1:0];
				REG_EB:   regs_q.element_bytes     <= cfg.payload.data[EB_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// rank in range, perm entries of used axes distinct and below rank, no zero size
	always_comb begin
		logic [MAX_RANK-1:0]  seen;
		logic [AXIS_BITS-1:0] p;
		cfg_ok = (regs_q.rank != '0) && (regs_q.rank <= RANK_BITS'(MAX_RANK));
		seen   = '0;
		for (int d = 0; d < MAX_RANK; d++) begin
			p = perm_of(regs_q, AXIS_BITS'(d));
			if (RANK_BITS'(d) < regs_q.rank) begin
				if (RANK_BITS'(p) >= regs_q.rank || seen[p])
					cfg_ok = 1'b0;
				if (dim_of(regs_q, AXIS_BITS'(d)) == '0)
					cfg_ok = 1'b0;
				seen[p] = 1'b1;
			end
		end
	end

endmodule

[hdl/ttag_ctrl.sv]
// ttag_ctrl: sequencer for restart, stride build, offset accumulation and emit
// depends on ttag_pkg and ttag_tick_if
module ttag_ctrl import ttag_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	ttag_tick_if.sink tick,
	input  cfg_t     cfg_regs,
	input  logic     cfg_ok,
	input  status_t  status,
	output cmd_t     cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (tick.valid) begin
					if (tick.payload.restart)
						state_d = ST_CLEAR;
					else
						state_d = cfg_ok ? ST_MAC : ST_EMIT;
				end
			end
			ST_CLEAR: begin
				if (!cfg_ok)
					state_d = ST_EMIT;
				else if (cfg_regs.rank == RANK_BITS'(1))
					state_d = ST_MAC;
				else
					state_d = ST_STRIDE;
			end
			ST_STRIDE: begin
				if (status.stride_last)
					state_d = ST_MAC;
			end
			ST_MAC: begin
				if (status.mac_last)
					state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		tick.ready      = (state_q == ST_IDLE);
		cmd.clear       = (state_q == ST_CLEAR);
		cmd.stride_step = (state_q == ST_STRIDE);
		cmd.mac         = (state_q == ST_MAC);
		cmd.emit        = (state_q == ST_EMIT) && status.out_free;
		cmd.err         = !cfg_ok;
	end

endmodule

[hdl/ttag_dp.sv]
// ttag_dp: odometer, strides, element counter, offset accumulator and result register
// depends on ttag_pkg and ttag_addr_if
module ttag_dp import ttag_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg_regs,
	input  cmd_t       cmd,
	output status_t    status,
	ttag_addr_if.source addr
);

	logic [DIM_BITS-1:0]    digit_q  [MAX_RANK];
	logic [STRIDE_BITS-1:0] stride_q [MAX_RANK];
	logic [CNT_BITS-1:0]    cnt_q;
	logic [OFF_BITS-1:0]    acc_q;
	logic [AXIS_BITS-1:0]   mac_idx_q;
	logic [AXIS_BITS-1:0]   stride_idx_q;
	logic                   addr_valid_q;
	addr_t                  addr_q;

	logic [DIM_BITS-1:0]             digit_next [MAX_RANK];
	logic                            odo_carry;
	logic [RANK_BITS-1:0]            rank_m1;
	logic [DIM_BITS+STRIDE_BITS-1:0] stride_prod;
	logic [DIM_BITS+STRIDE_BITS-1:0] mac_prod;
	logic [OFF_BITS-1:0]             acc_next;
	logic [OFF_BITS+EB_BITS-1:0]     src_full;
	logic [CNT_BITS+EB_BITS-1:0]     dst_full;

	assign rank_m1     = cfg_regs.rank - RANK_BITS'(1);
	assign stride_prod = stride_q[stride_idx_q] * dim_of(cfg_regs, stride_idx_q);
	assign mac_prod    = digit_q[mac_idx_q] * stride_q[perm_of(cfg_regs, mac_idx_q)];
	assign acc_next    = acc_q + mac_prod[OFF_BITS-1:0];
	assign src_full    = acc_q * cfg_regs.element_bytes;
	assign dst_full    = cnt_q * cfg_regs.element_bytes;

	assign status.stride_last = (stride_idx_q == AXIS_BITS'(1));
	assign status.mac_last    = (RANK_BITS'(mac_idx_q) == rank_m1);
	assign status.out_free    = !addr_valid_q || addr.ready;

	assign addr.valid   = addr_valid_q;
	assign addr.payload = addr_q;

	// odometer step, innermost output axis first; sizes follow the permutation
	always_comb begin
		logic                carry;
		logic [DIM_BITS:0]   inc;
		logic [DIM_BITS-1:0] size;
		carry = 1'b1;
		for (int d = MAX_RANK - 1; d >= 0; d--) begin
			digit_next[d] = digit_q[d];
			inc  = {1'b0, digit_q[d]} + (DIM_BITS+1)'(1);
			size = dim_of(cfg_regs, perm_of(cfg_regs, AXIS_BITS'(d)));
			if (RANK_BITS'(d) < cfg_regs.rank && carry) begin
				if (inc < {1'b0, size}) begin
					digit_next[d] = inc[DIM_BITS-1:0];
					carry         = 1'b0;
				end else begin
					digit_next[d] = '0;
				end
			end
		end
		odo_carry = carry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_RANK; i++) begin
				digit_q[i]  <= '0;
				stride_q[i] <= '0;
			end
			cnt_q        <= '0;
			acc_q        <= '0;
			mac_idx_q    <= '0;
			stride_idx_q <= '0;
		end else begin
			if (cmd.clear) begin
				// innermost axis gets stride one, the rest are built in the stride steps
				for (int i = 0; i < MAX_RANK; i++) begin
					digit_q[i]  <= '0;
					stride_q[i] <= (!cmd.err && AXIS_BITS'(i) == rank_m1[AXIS_BITS-1:0])
						? STRIDE_BITS'(1) : '0;
				end
				cnt_q        <= '0;
				stride_idx_q <= rank_m1[AXIS_BITS-1:0];
			end
			if (cmd.stride_step) begin
				stride_q[stride_idx_q - AXIS_BITS'(1)] <= stride_prod[STRIDE_BITS-1:0];
				stride_idx_q <= stride_idx_q - AXIS_BITS'(1);
			end
			if (cmd.mac) begin
				acc_q     <= acc_next;
				mac_idx_q <= mac_idx_q + AXIS_BITS'(1);
			end
			if (cmd.emit) begin
				acc_q     <= '0;
				mac_idx_q <= '0;
				if (!cmd.err) begin
					for (int i = 0; i < MAX_RANK; i++)
						digit_q[i] <= digit_next[i];
					cnt_q <= odo_carry ? '0 : cnt_q + CNT_BITS'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			addr_valid_q <= 1'b1;
		end else if (addr.ready) begin
			addr_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			if (cmd.err) begin
				addr_q.src_byte_offset <= '0;
				addr_q.dst_byte_offset <= '0;
				addr_q.last            <= 1'b1;
				addr_q.error           <= 1'b1;
			end else begin
				addr_q.src_byte_offset <= src_full[OFF_BITS-1:0];
				addr_q.dst_byte_offset <= dst_full[OFF_BITS-1:0];
				addr_q.last            <= odo_carry;
				addr_q.error           <= 1'b0;
			end
		end
	end

	a_err_result: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.err) |=> (addr.valid && addr.payload.error && addr.payload.last
			&& addr.payload.src_byte_offset == '0 && addr.payload.dst_byte_offset == '0))
		else $error("error transaction with non-zero offsets");

	a_wrap_clears_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && !cmd.err && odo_carry) |=> (cnt_q == '0 && addr.payload.last))
		else $error("odometer wrap did not clear element count");

	a_mac_in_rank: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mac |-> (RANK_BITS'(mac_idx_q) < cfg_regs.rank))
		else $error("accumulation past rank");

	a_stride_idx: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.stride_step |-> (stride_idx_q != '0))
		else $error("stride step below axis zero");

endmodule

[hdl/tensor_transpose_address_gen_top.sv]
// tensor_transpose_address_gen_top: top level of the transpose address generator
// depends on ttag_pkg, the three channel interfaces, ttag_cfg_regs, ttag_ctrl, ttag_dp
//
//  channel | role | payload
//  tick    | sink | restart
//  addr    | src  | src_byte_offset, dst_byte_offset, last, error
//  cfg     | sink | index, data (always ready)
//
// a tick passes through the accepting idle step, one multiply-accumulate per output axis
// and the emit step; the result is registered at the emit step
// a restart tick adds one clear step and rank - 1 stride multiplies before the accumulation
// a tick under a bad configuration goes straight to the emit step, through the clear step with restart
// reset clears odometer, strides and count; registers take their documented values
// the next tick is taken while a result waits; a stalled result holds the emit step
module tensor_transpose_address_gen_top import ttag_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	ttag_tick_if.sink   tick,
	ttag_addr_if.source addr,
	ttag_cfg_if.sink    cfg
);

	cfg_t    cfg_regs;
	logic    cfg_ok;
	cmd_t    cmd;
	status_t status;

	ttag_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (cfg_regs),
		.cfg_ok (cfg_ok)
	);

	ttag_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.tick     (tick),
		.cfg_regs (cfg_regs),
		.cfg_ok   (cfg_ok),
		.status   (status),
		.cmd      (cmd)
	);

	ttag_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_regs (cfg_regs),
		.cmd      (cmd),
		.status   (status),
		.addr     (addr)
	);

endmodule

[sim/tb_tensor_transpose_address_gen_top.sv]
`timescale 1ns / 100ps
// testbench for tensor_transpose_address_gen_top: drives ticks and register writes,
// predicts each address transaction in a scoreboard class and checks it in order
// depends on ttag_pkg, the three channel interfaces and the rtl under hdl
module tb_tensor_transpose_address_gen_top;
	import ttag_pkg::*;

	localparam int TICKS_TARGET  = 1150;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int SETTLE_CYCLES = 16;

	class addr_scoreboard;
		cfg_t                   regs;
		logic [DIM_BITS-1:0]    digit [MAX_RANK];
		logic [STRIDE_BITS-1:0] stride [MAX_RANK];
		logic [CNT_BITS-1:0]    elem_count;
		addr_t                  expected_addrs [$];
		int                     errors;
		int                     results_seen;

		function new();
			regs.rank              = RANK_RESET;
			regs.input_dims_packed = DIMS_RESET;
			regs.perm_packed       = PERM_RESET;
			regs.element_bytes     = EB_RESET;
			foreach (digit[a]) begin
				digit[a]  = '0;
				stride[a] = '0;
			end
			elem_count   = '0;
			errors       = 0;
			results_seen = 0;
		endfunction

		function logic [DIM_BITS-1:0] axis_size(input int a);
			return regs.input_dims_packed[a*DIM_BITS +: DIM_BITS];
		endfunction

		function int src_axis(input int a);
			return int'(regs.perm_packed[a*PERM_ENT_BITS +: PERM_ENT_BITS]);
		endfunction

		function bit layout_ok();
			logic [MAX_RANK-1:0] seen;
			int                  p;
			seen = '0;
			if (regs.rank < 1 || regs.rank > MAX_RANK)
				return 1'b0;
			for (int d = 0; d < int'(regs.rank); d++) begin
				p = src_axis(d);
				if (p >= int'(regs.rank) || seen[p])
					return 1'b0;
				seen[p] = 1'b1;
				if (axis_size(d) == 0)
					return 1'b0;
			end
			return 1'b1;
		endfunction

		function void write_reg(input cfg_idx_t idx, input logic [CFG_DATA_BITS-1:0] value);
			case (idx)
				REG_RANK: regs.rank              = value[RANK_BITS-1:0];
				REG_DIMS: regs.input_dims_packed = value[DIMS_BITS-1:0];
				REG_PERM: regs.perm_packed       = value[PERM_BITS-1:0];
				REG_EB:   regs.element_bytes     = value[EB_BITS-1:0];
				default: ;
			endcase
		endfunction

		function void add_expected(input addr_t a);
			expected_addrs = {expected_addrs, a};
		endfunction

		function void note_tick(input tick_t t);
			addr_t       want;
			logic [63:0] src_elems;
			bit          ok;
			bit          carry;
			ok = layout_ok();
			if (t.restart) begin
				foreach (digit[a]) begin
					digit[a]  = '0;
					stride[a] = '0;
				end
				elem_count = '0;
				// row-major strides of the input, innermost axis last
				if (ok) begin
					stride[regs.rank - 1] = 1;
					for (int i = int'(regs.rank) - 2; i >= 0; i--)
						stride[i] = stride[i + 1] * axis_size(i + 1);
				end
			end
			if (!ok) begin
				want = '{src_byte_offset: '0, dst_byte_offset: '0, last: 1'b1, error: 1'b1};
				add_expected(want);
				return;
			end
			src_elems = '0;
			for (int d = 0; d < int'(regs.rank); d++)
				src_elems += 64'(digit[d]) * stride[src_axis(d)];
			want.src_byte_offset = OFF_BITS'(src_elems * regs.element_bytes);
			want.dst_byte_offset = OFF_BITS'(64'(elem_count) * regs.element_bytes);
			want.error           = 1'b0;
			// odometer in output order, a digit whose increment reaches or passes its size wraps and carries
			carry = 1'b1;
			for (int d = int'(regs.rank) - 1; d >= 0 && carry; d--) begin
				if (int'(digit[d]) + 1 < int'(axis_size(src_axis(d)))) begin
					digit[d]++;
					carry = 1'b0;
				end else begin
					digit[d] = '0;
				end
			end
			want.last  = carry;
			elem_count = carry ? '0 : elem_count + 1'b1;
			add_expected(want);
		endfunction

		function void flag(input string msg);
			errors++;
			if (errors <= 10)
				$display("%s", msg);
		endfunction

		function void check_addr(input addr_t got);
			addr_t want;
			string bad;
			results_seen++;
			if (expected_addrs.size() == 0) begin
				flag($sformatf("address %0d with no tick outstanding: src %0h dst %0h last %b error %b",
					results_seen, got.src_byte_offset, got.dst_byte_offset, got.last, got.error));
				return;
			end
			want = expected_addrs.pop_front();
			bad  = "";
			if (got.src_byte_offset !== want.src_byte_offset)
				bad = {bad, " src_byte_offset"};
			if (got.dst_byte_offset !== want.dst_byte_offset)
				bad = {bad, " dst_byte_offset"};
			if (got.last !== want.last)
				bad = {bad, " last"};
			if (got.error !== want.error)
				bad = {bad, " error"};
			if (bad != "")
				flag($sformatf({"address %0d mismatch in%s: expected src %0h dst %0h last %b ",
					"error %b, got src %0h dst %0h last %b error %b"}, results_seen, bad,
					want.src_byte_offset, want.dst_byte_offset, want.last, want.error,
					got.src_byte_offset, got.dst_byte_offset, got.last, got.error));
		endfunction
	endclass

	logic           clk = 1'b0;
	logic           arst_n;
	int             tx_idle_pct = 36;
	int             rx_idle_pct = 55;
	int             ticks_sent  = 0;
	int             cycle_count;
	addr_scoreboard sb = new();

	ttag_tick_if tick_bus ();
	ttag_addr_if addr_bus ();
	ttag_cfg_if  cfg_bus ();

	tensor_transpose_address_gen_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick_bus),
		.addr   (addr_bus),
		.cfg    (cfg_bus)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		addr_bus.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
	end

	// every transaction is taken from the values present at the edge
	always @(posedge clk) begin
		if (cfg_bus.valid && cfg_bus.ready)
			sb.write_reg(cfg_bus.payload.index, cfg_bus.payload.data);
		if (tick_bus.valid && tick_bus.ready)
			sb.note_tick(tick_bus.payload);
		if (addr_bus.valid && addr_bus.ready)
			sb.check_addr(addr_bus.payload);
	end

	task automatic send_tick(input logic restart_bit);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			tick_bus.valid <= 1'b0;
			@(posedge clk);
		end
		tick_bus.valid   <= 1'b1;
		tick_bus.payload <= '{restart: restart_bit};
		do @(posedge clk); while (!tick_bus.ready);
		ticks_sent++;
	endtask

	task automatic wait_results();
		tick_bus.valid <= 1'b0;
		do @(posedge clk); while (sb.expected_addrs.size() != 0);
	endtask

	task automatic put_reg(input cfg_idx_t idx, input logic [CFG_DATA_BITS-1:0] value);
		cfg_bus.valid   <= 1'b1;
		cfg_bus.payload <= '{index: idx, data: value};
		do @(posedge clk); while (!cfg_bus.ready);
	endtask

	// noisy adds a write to an unmapped index and junk above the narrow fields
	task automatic apply_regs(input logic [3:0] which, input cfg_t s, input bit noisy);
		logic [CFG_DATA_BITS-1:0] spare;
		spare = noisy ? CFG_DATA_BITS'({$urandom, $urandom}) : '0;
		if (noisy)
			put_reg(cfg_idx_t'($urandom_range(int'(REG_EB) + 1, 255)), spare);
		if (which[REG_RANK])
			put_reg(REG_RANK, {spare[CFG_DATA_BITS-1:RANK_BITS], s.rank});
		if (which[REG_DIMS])
			put_reg(REG_DIMS, s.input_dims_packed);
		if (which[REG_PERM])
			put_reg(REG_PERM, {spare[CFG_DATA_BITS-1:PERM_BITS], s.perm_packed});
		if (which[REG_EB])
			put_reg(REG_EB, {spare[CFG_DATA_BITS-1:EB_BITS], s.element_bytes});
		cfg_bus.valid <= 1'b0;
	endtask

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_tensor_transpose_address_gen_top: done, errors");
		$finish;
	end

	initial begin
		cfg_t                layout;
		logic [DIM_BITS-1:0] axis_len;
		int                  order [MAX_RANK];
		int                  used;
		int                  roll;
		int                  j;
		int                  tmp;
		int                  seg_len;

		arst_n           <= 1'b0;
		tick_bus.valid   <= 1'b0;
		tick_bus.payload <= '0;
		cfg_bus.valid    <= 1'b0;
		cfg_bus.payload  <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// reset layout, strides stay zero until the first restart
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b0);
		wait_results();

		layout = '{rank: 3'd1, input_dims_packed: '1, perm_packed: '0, element_bytes: 4'd15};
		apply_regs(4'b1111, layout, 1'b1);
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b0);
		wait_results();

		layout = '{rank: 3'd4, input_dims_packed: '1, perm_packed: 8'hE4, element_bytes: 4'd8};
		apply_regs(4'b1111, layout, 1'b0);
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b0);
		wait_results();

		// shrink every axis without restart, the running digit is now past its size
		layout.input_dims_packed = {4{12'd2}};
		apply_regs(4'b0010, layout, 1'b0);
		send_tick(1'b0);
		send_tick(1'b0);
		wait_results();

		layout.element_bytes = '0;
		apply_regs(4'b1000, layout, 1'b0);
		send_tick(1'b0);
		wait_results();

		// unusable layouts: no axes, too many axes, repeated axis, axis out of range
		layout.rank = '0;
		apply_regs(4'b0001, layout, 1'b0);
		send_tick(1'b0);
		send_tick(1'b1);
		wait_results();
		layout.rank = 3'd5;
		apply_regs(4'b0001, layout, 1'b0);
		send_tick(1'b0);
		wait_results();
		layout = '{rank: 3'd3, input_dims_packed: {12'd5, 12'd4, 12'd3, 12'd2},
			perm_packed: 8'h05, element_bytes: 4'd3};
		apply_regs(4'b1111, layout, 1'b0);
		send_tick(1'b0);
		wait_results();
		layout.rank        = 3'd2;
		layout.perm_packed = 8'h0C;
		apply_regs(4'b0101, layout, 1'b0);
		send_tick(1'b0);
		wait_results();

		// zero-sized axis with restart, then fix it and walk the 3x2 tensor to its end
		layout.perm_packed       = 8'hE4;
		layout.input_dims_packed = {12'hABC, 12'h5A5, 12'd0, 12'd3};
		apply_regs(4'b0110, layout, 1'b0);
		send_tick(1'b1);
		wait_results();
		layout.input_dims_packed = {12'hABC, 12'h5A5, 12'd2, 12'd3};
		apply_regs(4'b0010, layout, 1'b0);
		send_tick(1'b0);
		send_tick(1'b0);
		send_tick(1'b1);
		repeat (5) send_tick(1'b0);
		wait_results();

		while (ticks_sent < TICKS_TARGET) begin
			if (ticks_sent >= 2 * TICKS_TARGET / 3) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end else if (ticks_sent >= TICKS_TARGET / 3) begin
				tx_idle_pct = 55;
				rx_idle_pct = 36;
			end

			roll = $urandom_range(0, 99);
			layout.rank = (roll < 88) ? RANK_BITS'($urandom_range(1, MAX_RANK))
				: RANK_BITS'($urandom_range(0, 7));
			used = (layout.rank >= 1 && layout.rank <= MAX_RANK) ? int'(layout.rank) : MAX_RANK;
			for (int a = 0; a < MAX_RANK; a++) begin
				roll = $urandom_range(0, 99);
				if (roll < 86)
					axis_len = DIM_BITS'($urandom_range(1, 3));
				else if (roll < 90)
					axis_len = '0;
				else
					axis_len = DIM_BITS'($urandom);
				layout.input_dims_packed[a*DIM_BITS +: DIM_BITS] = axis_len;
				order[a] = (a < used) ? a : int'($urandom_range(0, MAX_RANK - 1));
			end
			// shuffle the axes in use into a proper permutation
			for (int a = used - 1; a > 0; a--) begin
				j        = $urandom_range(0, a);
				tmp      = order[a];
				order[a] = order[j];
				order[j] = tmp;
			end
			for (int a = 0; a < MAX_RANK; a++)
				layout.perm_packed[a*PERM_ENT_BITS +: PERM_ENT_BITS] = PERM_ENT_BITS'(order[a]);
			if ($urandom_range(0, 99) < 12)
				layout.perm_packed = PERM_BITS'($urandom);
			layout.element_bytes = ($urandom_range(0, 99) < 80) ? EB_BITS'($urandom_range(1, 8))
				: EB_BITS'($urandom);
			apply_regs(4'($urandom_range(1, 15)), layout, $urandom_range(0, 9) == 0);

			// mostly a restart then a clean walk, sometimes carry on from stale state
			seg_len = $urandom_range(8, 60);
			send_tick($urandom_range(0, 99) < 85);
			for (int k = 1; k < seg_len; k++)
				send_tick($urandom_range(0, 99) < 3);
			wait_results();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.expected_addrs.size() == 0)
			$display("tb_tensor_transpose_address_gen_top: done, clean");
		else
			$display("tb_tensor_transpose_address_gen_top: done, errors");
		$finish;
	end

endmodule
